[hdl/csv_line_field_splitter_unit_macros.svh]
// Assertion helpers shared by the splitter modules.
`ifndef CSV_LINE_FIELD_SPLITTER_UNIT_MACROS_SVH
`define CSV_LINE_FIELD_SPLITTER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

`define CSVS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("csvs assertion failed");

`define CSVS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("csvs assertion failed");

`else

`define CSVS_ASSERT_NOW(lbl, clk, rst, ante, cons)

`define CSVS_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

[hdl/csvs_pkg.sv]
`default_nettype none

package csvs_pkg;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned CSR_ADDR_W = 3;

   localparam logic [BYTE_W-1:0] QUOTE_BYTE = 8'h22;
   localparam logic [BYTE_W-1:0] CR_BYTE    = 8'h0D;
   localparam logic [BYTE_W-1:0] LF_BYTE    = 8'h0A;

   localparam logic [BYTE_W-1:0] DELIM_FIRST_RESET  = 8'd44;
   localparam logic [BYTE_W-1:0] DELIM_SECOND_RESET = 8'd59;

   typedef enum logic [1:0] {
      KIND_BYTE           = 2'd0,
      KIND_FIELD_END      = 2'd1,
      KIND_FIELD_LINE_END = 2'd2,
      KIND_LINE_END       = 2'd3
   } kind_type;

   typedef enum logic {
      REG_DELIM_FIRST  = 1'b0,
      REG_DELIM_SECOND = 1'b1
   } csr_reg_type;

   typedef struct packed {
      kind_type          kind;
      logic [BYTE_W-1:0] value;
      logic              last;
   } res_type;

   // results caused by one item: none, one, or two
   typedef struct packed {
      logic    load;
      logic    two;
      res_type first;
      res_type second;
   } pair_type;

endpackage

`default_nettype wire

[hdl/csvs_stream_if.sv]
`default_nettype none

interface csvs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       line_last;

   modport source (output valid, output text_byte, output line_last, input ready);
   modport sink (input valid, input text_byte, input line_last, output ready);
endinterface

interface csvs_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] value;
   logic       last;

   modport source (output valid, output kind, output value, output last, input ready);
   modport sink (input valid, input kind, input value, input last, output ready);
endinterface

`default_nettype wire

[hdl/csv_line_field_splitter_unit.sv]
// The first result of an accepted item is registered and shows on rsp in the
// cycle after. Throughput: one item per cycle while rsp is ready and each item
// yields at most one result; an item with two results (a byte or field end plus
// the line end) holds req until the first leaves; results drain one per cycle.
// Reset (synchronous, active high) clears the parse state and the output
// register and returns the delimiters to comma and semicolon.
`default_nettype none

module csv_line_field_splitter_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   csvs_req_if.sink                             req_chan,
   csvs_rsp_if.source                           rsp_chan,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [csvs_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [csvs_pkg::CSR_DATA_W-1:0] pwdata,
   output logic      [csvs_pkg::CSR_DATA_W-1:0] prdata,
   output logic                                 pready
);
   import csvs_pkg::*;

   logic [BYTE_W-1:0] delim_first;
   logic [BYTE_W-1:0] delim_second;
   logic              accept;
   logic              req_ready;
   pair_type          pair;
   res_type           rsp_res;

   assign accept         = req_chan.valid & req_ready;
   assign req_chan.ready = req_ready;

   csvs_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .delim_first  (delim_first),
      .delim_second (delim_second)
   );

   csvs_parse u_parse (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .text_byte    (req_chan.text_byte),
      .line_last    (req_chan.line_last),
      .delim_first  (delim_first),
      .delim_second (delim_second),
      .pair         (pair)
   );

   csvs_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .pair      (pair),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_res   (rsp_res),
      .req_ready (req_ready)
   );

   assign rsp_chan.kind  = rsp_res.kind;
   assign rsp_chan.value = rsp_res.value;
   assign rsp_chan.last  = rsp_res.last;

endmodule

`default_nettype wire

[hdl/csvs_csr.sv]
`default_nettype none

module csvs_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [csvs_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [csvs_pkg::CSR_DATA_W-1:0] pwdata,
   output logic      [csvs_pkg::CSR_DATA_W-1:0] prdata,
   output logic                                 pready,
   output logic      [csvs_pkg::BYTE_W-1:0]     delim_first,
   output logic      [csvs_pkg::BYTE_W-1:0]     delim_second
);
   import csvs_pkg::*;

   logic [BYTE_W-1:0] delim_first_ff, delim_first_in;
   logic [BYTE_W-1:0] delim_second_ff, delim_second_in;
   csr_reg_type       reg_sel;
   logic              wr_en;

   // registers sit on 4-byte strides, so the word index is the top address bit
   assign reg_sel = csr_reg_type'(paddr[CSR_ADDR_W-1]);
   assign wr_en   = psel & penable & pwrite;
   assign pready  = 1'b1;

   always_comb begin
      delim_first_in  = delim_first_ff;
      delim_second_in = delim_second_ff;
      prdata          = '0;
      unique case (reg_sel)
         REG_DELIM_FIRST: begin
            if (wr_en) delim_first_in = pwdata[BYTE_W-1:0];
            prdata = {{(CSR_DATA_W-BYTE_W){1'b0}}, delim_first_ff};
         end
         REG_DELIM_SECOND: begin
            if (wr_en) delim_second_in = pwdata[BYTE_W-1:0];
            prdata = {{(CSR_DATA_W-BYTE_W){1'b0}}, delim_second_ff};
         end
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delim_first_ff  <= DELIM_FIRST_RESET;
         delim_second_ff <= DELIM_SECOND_RESET;
      end else begin
         delim_first_ff  <= delim_first_in;
         delim_second_ff <= delim_second_in;
      end
   end

   assign delim_first  = delim_first_ff;
   assign delim_second = delim_second_ff;

endmodule

`default_nettype wire

[hdl/csvs_parse.sv]
`default_nettype none

module csvs_parse (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        accept,
   input  wire logic [csvs_pkg::BYTE_W-1:0] text_byte,
   input  wire logic                        line_last,
   input  wire logic [csvs_pkg::BYTE_W-1:0] delim_first,
   input  wire logic [csvs_pkg::BYTE_W-1:0] delim_second,
   output csvs_pkg::pair_type               pair
);
   import csvs_pkg::*;
   `include "csv_line_field_splitter_unit_macros.svh"

   logic              in_quotes_ff, in_quotes_in;
   logic              quote_pending_ff, quote_pending_in;
   logic              delim_locked_ff, delim_locked_in;
   logic [BYTE_W-1:0] locked_delim_ff, locked_delim_in;
   logic              field_has_bytes_ff, field_has_bytes_in;
   logic              line_stopped_ff, line_stopped_in;

   always_comb begin
      logic    consumed;
      logic    is_delim;
      logic    emit;
      res_type body;
      res_type eol;

      in_quotes_in       = in_quotes_ff;
      quote_pending_in   = quote_pending_ff;
      delim_locked_in    = delim_locked_ff;
      locked_delim_in    = locked_delim_ff;
      field_has_bytes_in = field_has_bytes_ff;
      line_stopped_in    = line_stopped_ff;
      consumed           = 1'b0;
      is_delim           = 1'b0;
      emit               = 1'b0;
      body               = '{kind: KIND_BYTE, value: '0, last: 1'b1};
      eol                = '{kind: KIND_LINE_END, value: '0, last: 1'b1};

      if (!line_stopped_ff) begin
         // a held quote is settled by this byte before anything else
         if (quote_pending_ff) begin
            quote_pending_in = 1'b0;
            if (text_byte == QUOTE_BYTE) begin
               emit               = 1'b1;
               body.value         = QUOTE_BYTE;
               field_has_bytes_in = 1'b1;
               consumed           = 1'b1;
            end else begin
               in_quotes_in = !in_quotes_ff;
            end
         end

         if (!consumed) begin
            if (text_byte == CR_BYTE || text_byte == LF_BYTE) begin
               line_stopped_in = 1'b1;
            end else if (in_quotes_in) begin
               if (text_byte == QUOTE_BYTE) begin
                  quote_pending_in = 1'b1;
               end else begin
                  emit               = 1'b1;
                  body.value         = text_byte;
                  field_has_bytes_in = 1'b1;
               end
            end else begin
               if (!delim_locked_ff) begin
                  is_delim = (text_byte == delim_first) || (text_byte == delim_second);
                  if (is_delim) begin
                     delim_locked_in = 1'b1;
                     locked_delim_in = text_byte;
                  end
               end else begin
                  is_delim = (text_byte == locked_delim_ff);
               end

               if (is_delim) begin
                  emit               = 1'b1;
                  body.kind          = KIND_FIELD_END;
                  field_has_bytes_in = 1'b0;
               end else if (text_byte == QUOTE_BYTE) begin
                  quote_pending_in = 1'b1;
               end else begin
                  emit               = 1'b1;
                  body.value         = text_byte;
                  field_has_bytes_in = 1'b1;
               end
            end
         end
      end

      eol.kind = field_has_bytes_in ? KIND_FIELD_LINE_END : KIND_LINE_END;

      pair.load   = emit | line_last;
      pair.two    = emit & line_last;
      pair.first  = emit ? body : eol;
      pair.second = eol;
      if (emit && line_last) pair.first.last = 1'b0;

      if (line_last) begin
         in_quotes_in       = 1'b0;
         quote_pending_in   = 1'b0;
         delim_locked_in    = 1'b0;
         locked_delim_in    = '0;
         field_has_bytes_in = 1'b0;
         line_stopped_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_quotes_ff       <= 1'b0;
         quote_pending_ff   <= 1'b0;
         delim_locked_ff    <= 1'b0;
         locked_delim_ff    <= '0;
         field_has_bytes_ff <= 1'b0;
         line_stopped_ff    <= 1'b0;
      end else if (accept) begin
         in_quotes_ff       <= in_quotes_in;
         quote_pending_ff   <= quote_pending_in;
         delim_locked_ff    <= delim_locked_in;
         locked_delim_ff    <= locked_delim_in;
         field_has_bytes_ff <= field_has_bytes_in;
         line_stopped_ff    <= line_stopped_in;
      end
   end

   `CSVS_ASSERT_NOW(a_stop_no_pending, clock, reset, line_stopped_ff, !quote_pending_ff)
   `CSVS_ASSERT_NEXT(a_line_end_clears, clock, reset, accept && line_last,
      !delim_locked_ff && !in_quotes_ff && !line_stopped_ff)

endmodule

`default_nettype wire

[hdl/csvs_outq.sv]
`default_nettype none

module csvs_outq (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire csvs_pkg::pair_type pair,
   input  wire logic               rsp_ready,
   output logic                    rsp_valid,
   output csvs_pkg::res_type       rsp_res,
   output logic                    req_ready
);
   import csvs_pkg::*;
   `include "csv_line_field_splitter_unit_macros.svh"

   res_type head_ff, head_in;
   res_type tail_ff, tail_in;
   logic    head_valid_ff, head_valid_in;
   logic    tail_valid_ff, tail_valid_in;
   logic    pop;

   assign pop       = head_valid_ff & rsp_ready;
   // new pair fits if no second result waits and the head is empty or leaves
   assign req_ready = !tail_valid_ff && (!head_valid_ff || rsp_ready);

   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      head_valid_in = head_valid_ff;
      tail_valid_in = tail_valid_ff;
      if (pop) begin
         head_in       = tail_ff;
         head_valid_in = tail_valid_ff;
         tail_valid_in = 1'b0;
      end
      if (accept && pair.load) begin
         head_in       = pair.first;
         head_valid_in = 1'b1;
         tail_in       = pair.second;
         tail_valid_in = pair.two;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         tail_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         tail_valid_ff <= tail_valid_in;
      end
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   assign rsp_valid = head_valid_ff;
   assign rsp_res   = head_ff;

   `CSVS_ASSERT_NOW(a_tail_needs_head, clock, reset, tail_valid_ff, head_valid_ff)
   `CSVS_ASSERT_NOW(a_not_last_has_tail, clock, reset,
      head_valid_ff && !head_ff.last, tail_valid_ff)
   `CSVS_ASSERT_NEXT(a_pair_loads_both, clock, reset, accept && pair.load && pair.two,
      head_valid_ff && tail_valid_ff)

endmodule

`default_nettype wire

[sim/csv_line_field_splitter_unit_test.sv]
`timescale 1ns / 1ps

module csv_line_field_splitter_unit_test;
   import csvs_pkg::*;

   typedef struct {
      logic [7:0] text;
      logic       eol;
      int         typed;   // number of typed results, -1: use the splitter model
      res_type    first;
      res_type    second;
   } probe_row_type;

   localparam res_type NO_RES = res_type'{KIND_BYTE, 8'h00, 1'b0};

   // directed lines, default delimiters (comma, semicolon)
   probe_row_type probe_rows [24] = '{
      '{8'h61, 1'b0, 1, res_type'{KIND_BYTE, 8'h61, 1'b1}, NO_RES},
      '{8'h2C, 1'b0, 1, res_type'{KIND_FIELD_END, 8'h00, 1'b1}, NO_RES},
      '{8'h3B, 1'b0, -1, NO_RES, NO_RES},
      '{8'hFF, 1'b1, 2, res_type'{KIND_BYTE, 8'hFF, 1'b0},
                        res_type'{KIND_FIELD_LINE_END, 8'h00, 1'b1}},
      '{8'h00, 1'b1, 2, res_type'{KIND_BYTE, 8'h00, 1'b0},
                        res_type'{KIND_FIELD_LINE_END, 8'h00, 1'b1}},
      '{8'h2C, 1'b1, 2, res_type'{KIND_FIELD_END, 8'h00, 1'b0},
                        res_type'{KIND_LINE_END, 8'h00, 1'b1}},
      '{LF_BYTE, 1'b1, 1, res_type'{KIND_LINE_END, 8'h00, 1'b1}, NO_RES},
      '{QUOTE_BYTE, 1'b0, 0, NO_RES, NO_RES},
      '{8'h78, 1'b0, -1, NO_RES, NO_RES},
      '{8'h2C, 1'b0, -1, NO_RES, NO_RES},
      '{QUOTE_BYTE, 1'b0, -1, NO_RES, NO_RES},
      '{QUOTE_BYTE, 1'b0, -1, NO_RES, NO_RES},
      '{QUOTE_BYTE, 1'b0, -1, NO_RES, NO_RES},
      '{8'h7A, 1'b0, -1, NO_RES, NO_RES},
      '{QUOTE_BYTE, 1'b1, -1, NO_RES, NO_RES},
      '{QUOTE_BYTE, 1'b0, -1, NO_RES, NO_RES},
      '{CR_BYTE, 1'b0, -1, NO_RES, NO_RES},
      '{8'h6B, 1'b0, -1, NO_RES, NO_RES},
      '{8'h2C, 1'b1, -1, NO_RES, NO_RES},
      '{8'h3B, 1'b0, -1, NO_RES, NO_RES},
      '{8'h2C, 1'b0, -1, NO_RES, NO_RES},
      '{8'h3B, 1'b1, -1, NO_RES, NO_RES},
      '{8'h80, 1'b0, -1, NO_RES, NO_RES},
      '{8'h7F, 1'b1, -1, NO_RES, NO_RES}
   };

   logic [7:0] phase_first  [8] = '{8'd44, 8'd0, QUOTE_BYTE, 8'd9, 8'd255, 8'd44, CR_BYTE, 8'd44};
   logic [7:0] phase_second [8] = '{8'd59, 8'd255, QUOTE_BYTE, 8'd124, 8'd0, 8'd44, 8'd44, 8'd59};

   logic clock;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   csvs_req_if req_bus ();
   csvs_rsp_if rsp_bus ();

   csv_line_field_splitter_unit DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // splitter model state
   logic [7:0] sep_first  = DELIM_FIRST_RESET;
   logic [7:0] sep_second = DELIM_SECOND_RESET;
   bit         quoted      = 1'b0;
   bit         quote_held  = 1'b0;
   bit         sep_locked  = 1'b0;
   logic [7:0] sep_byte    = 8'h00;
   bit         field_open  = 1'b0;
   bit         line_halted = 1'b0;

   res_type awaited [$];
   res_type want_res;
   int mismatches    = 0;
   int counted_items = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_cycles   = 0;

   task automatic note_mismatch(input string what, input int got, input int want);
      $display("%0t: %s: got %0h, want %0h", $time, what, got, want);
      mismatches++;
   endtask

   function automatic res_type res_of(input kind_type k, input logic [7:0] v);
      return res_type'{k, v, 1'b0};
   endfunction

   function automatic void split_byte(input logic [7:0] b, input logic eol,
                                      output res_type got [$]);
      bit taken;
      bit is_sep;
      got = {};
      taken = 1'b0;
      if (!line_halted) begin
         if (quote_held) begin
            quote_held = 1'b0;
            if (b == QUOTE_BYTE) begin
               got = {got, res_of(KIND_BYTE, QUOTE_BYTE)};
               field_open = 1'b1;
               taken = 1'b1;
            end else begin
               quoted = !quoted;
            end
         end
         if (!taken) begin
            if (b == CR_BYTE || b == LF_BYTE) begin
               line_halted = 1'b1;
            end else if (quoted) begin
               if (b == QUOTE_BYTE) begin
                  quote_held = 1'b1;
               end else begin
                  got = {got, res_of(KIND_BYTE, b)};
                  field_open = 1'b1;
               end
            end else begin
               if (!sep_locked) begin
                  is_sep = (b == sep_first) || (b == sep_second);
                  if (is_sep) begin
                     sep_locked = 1'b1;
                     sep_byte = b;
                  end
               end else begin
                  is_sep = (b == sep_byte);
               end
               if (is_sep) begin
                  got = {got, res_of(KIND_FIELD_END, 8'h00)};
                  field_open = 1'b0;
               end else if (b == QUOTE_BYTE) begin
                  quote_held = 1'b1;
               end else begin
                  got = {got, res_of(KIND_BYTE, b)};
                  field_open = 1'b1;
               end
            end
         end
      end
      if (eol) begin
         got = {got, res_of(field_open ? KIND_FIELD_LINE_END : KIND_LINE_END, 8'h00)};
         quoted = 1'b0;
         quote_held = 1'b0;
         sep_locked = 1'b0;
         sep_byte = 8'h00;
         field_open = 1'b0;
         line_halted = 1'b0;
      end
      if (got.size() > 0)
         got[got.size()-1].last = 1'b1;
   endfunction

   task automatic send_item(input logic [7:0] b, input logic eol, input int typed,
                            input res_type r0, input res_type r1);
      res_type got [$];
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.text_byte <= b;
      req_bus.line_last <= eol;
      do @(posedge clock); while (!req_bus.ready);
      // bytes after a line break do nothing, so they don't count
      if (!line_halted || eol)
         counted_items++;
      split_byte(b, eol, got);
      if (typed < 0) begin
         awaited = {awaited, got};
      end else begin
         if (typed > 0) awaited = {awaited, r0};
         if (typed > 1) awaited = {awaited, r1};
      end
   endtask

   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(255));
      while (b == QUOTE_BYTE || b == CR_BYTE || b == LF_BYTE || b == sep_first
             || b == sep_second);
      return b;
   endfunction

   function automatic logic [7:0] noise_byte();
      case ($urandom_range(9))
         0: return QUOTE_BYTE;
         1: return sep_first;
         2: return sep_second;
         3: return $urandom_range(1) ? CR_BYTE : LF_BYTE;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic send_random_line();
      logic [7:0] text [$];
      logic [7:0] sep;
      logic [7:0] other;
      int nfields;
      int len;
      if ($urandom_range(99) < 80) begin
         nfields = $urandom_range(4);
         sep = $urandom_range(1) ? sep_first : sep_second;
         other = (sep == sep_first) ? sep_second : sep_first;
         for (int f = 0; f <= nfields; f++) begin
            // sometimes the other delimiter, data unless it comes first
            if (f > 0) text = {text, ($urandom_range(9) == 0) ? other : sep};
            len = $urandom_range(5);
            if ($urandom_range(2) == 0) begin
               text = {text, QUOTE_BYTE};
               for (int k = 0; k < len; k++) begin
                  case ($urandom_range(5))
                     0: text = {text, sep};
                     1: begin
                        text = {text, QUOTE_BYTE};
                        text = {text, QUOTE_BYTE};
                     end
                     default: text = {text, plain_byte()};
                  endcase
               end
               text = {text, QUOTE_BYTE};
            end else begin
               for (int k = 0; k < len; k++) text = {text, plain_byte()};
            end
         end
         case ($urandom_range(5))
            0: text = {text, CR_BYTE};
            1: text = {text, LF_BYTE};
            2: begin
               text = {text, CR_BYTE};
               text = {text, LF_BYTE};
               len = $urandom_range(3);
               for (int k = 0; k < len; k++) text = {text, noise_byte()};
            end
            default: ;
         endcase
      end else begin
         len = $urandom_range(1, 10);
         for (int k = 0; k < len; k++) text = {text, noise_byte()};
      end
      if (text.size() == 0) text = {text, noise_byte()};
      foreach (text[i])
         send_item(text[i], i == text.size() - 1, -1, NO_RES, NO_RES);
   endtask

   task automatic write_reg(input csr_reg_type which, input logic [7:0] val);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {which, 2'b00};
      pwdata  <= {24'h0, val};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (which == REG_DELIM_FIRST)
         sep_first = val;
      else
         sep_second = val;
      // read it back
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== {24'h0, val})
         note_mismatch("register readback", prdata, val);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      while (awaited.size() != 0) @(posedge clock);
      // an item with no result may still be in flight
      repeat (4) @(posedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_cycles--;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (awaited.size() == 0) begin
            note_mismatch("item with nothing expected, kind", rsp_bus.kind, 0);
         end else begin
            want_res = awaited.pop_front();
            if (rsp_bus.kind !== want_res.kind)
               note_mismatch("kind", rsp_bus.kind, want_res.kind);
            if (rsp_bus.value !== want_res.value)
               note_mismatch("value", rsp_bus.value, want_res.value);
            if (rsp_bus.last !== want_res.last)
               note_mismatch("last", rsp_bus.last, want_res.last);
         end
      end
   end

   initial begin
      #2_000_000;
      $display("csv_line_field_splitter_unit_test failed");
      $finish;
   end

   initial begin
      int goal;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.text_byte = 8'h00;
      req_bus.line_last = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (probe_rows[i])
         send_item(probe_rows[i].text, probe_rows[i].eol, probe_rows[i].typed,
                   probe_rows[i].first, probe_rows[i].second);

      for (int p = 0; p < 8; p++) begin
         settle();
         if (p > 0) begin
            write_reg(REG_DELIM_FIRST, phase_first[p]);
            write_reg(REG_DELIM_SECOND, phase_second[p]);
         end
         case (p % 4)
            0: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 88;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               recv_stall_pct = 88;
            end
            default: begin
               send_idle_pct = 22;
               recv_stall_pct = 22;
            end
         endcase
         // long receiver hold-off while items keep coming
         if (p == 4) hold_cycles = 250;
         goal = counted_items + 225;
         while (counted_items < goal) send_random_line();
      end
      settle();

      if (mismatches == 0)
         $display("csv_line_field_splitter_unit_test passed");
      else
         $display("csv_line_field_splitter_unit_test failed");
      $finish;
   end

endmodule
